@@ design/record_crc_seal_verify_macros.svh @@
// Assertion macros for the record CRC seal/verify block.
// Used only by the top level; no other dependencies.
`ifndef RECORD_CRC_SEAL_VERIFY_MACROS_SVH
`define RECORD_CRC_SEAL_VERIFY_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCSV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RCSV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rcsv_pkg.sv @@
// Shared types, codes and the CRC-16 byte fold for the record CRC block.
// No dependencies.
package rcsv_pkg;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic OP_SEAL   = 1'b0;
  localparam logic OP_VERIFY = 1'b1;

  localparam logic [1:0] STATUS_SEALED   = 2'd0;
  localparam logic [1:0] STATUS_MATCH    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  // header position of a record being verified
  localparam logic [1:0] POS_VERSION = 2'd0;
  localparam logic [1:0] POS_CRC_HI  = 2'd1;
  localparam logic [1:0] POS_CRC_LO  = 2'd2;
  localparam logic [1:0] POS_PAYLOAD = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic [1:0]  result_status;
  } res_t;

  // reflected CRC-16, one byte, unrolled
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/rcsv_in_stage.sv @@
// Input register stage for the record CRC block.
// Depends on rcsv_pkg.
module rcsv_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rcsv_pkg::item_t in_item,
  input  logic          advance,
  output logic          stage_valid,
  output rcsv_pkg::item_t stage_item
);

  logic            valid;
  rcsv_pkg::item_t item;

  assign in_ready    = !valid || advance;
  assign stage_valid = valid;
  assign stage_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ design/rcsv_engine.sv @@
// Record state and CRC update: one byte per request, result on the last byte.
// Depends on rcsv_pkg.
module rcsv_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  rcsv_pkg::item_t item,
  output rcsv_pkg::res_t  result
);

  logic [15:0] crc_reg, crc_reg_next;
  logic [1:0]  pos, pos_next;
  logic [7:0]  version, version_next;
  logic [15:0] stored, stored_next;

  logic [15:0] crc_pay;
  logic [15:0] crc_upd;
  logic [7:0]  ver_use;
  logic [15:0] stored_use;
  logic [15:0] final_crc;
  logic        verify;

  assign verify     = (item.operation == rcsv_pkg::OP_VERIFY);
  assign crc_pay    = rcsv_pkg::crc_fold(crc_reg, item.data_byte);
  assign crc_upd    = (!verify || pos == rcsv_pkg::POS_PAYLOAD) ? crc_pay : crc_reg;
  assign ver_use    = (pos == rcsv_pkg::POS_VERSION) ? item.data_byte : version;
  assign stored_use = (pos == rcsv_pkg::POS_CRC_LO) ? {stored[15:8], item.data_byte} : stored;
  assign final_crc  = rcsv_pkg::crc_fold(crc_upd, ver_use);

  always_comb begin
    if (!verify) begin
      result.crc_value     = crc_pay;
      result.result_status = rcsv_pkg::STATUS_SEALED;
    end else begin
      result.crc_value = final_crc;
      // header cut short before the CRC was complete
      if (pos == rcsv_pkg::POS_VERSION || pos == rcsv_pkg::POS_CRC_HI) begin
        result.result_status = rcsv_pkg::STATUS_MISMATCH;
      end else if (final_crc == stored_use) begin
        result.result_status = rcsv_pkg::STATUS_MATCH;
      end else begin
        result.result_status = rcsv_pkg::STATUS_MISMATCH;
      end
    end
  end

  always_comb begin
    crc_reg_next = crc_reg;
    pos_next     = pos;
    version_next = version;
    stored_next  = stored;
    if (item.last) begin
      crc_reg_next = rcsv_pkg::CRC_START;
      pos_next     = rcsv_pkg::POS_VERSION;
      version_next = 8'h00;
      stored_next  = 16'h0000;
    end else if (!verify) begin
      crc_reg_next = crc_pay;
    end else begin
      crc_reg_next = crc_upd;
      case (pos)
        rcsv_pkg::POS_VERSION: begin
          version_next = item.data_byte;
          pos_next     = rcsv_pkg::POS_CRC_HI;
        end
        rcsv_pkg::POS_CRC_HI: begin
          stored_next = {item.data_byte, stored[7:0]};
          pos_next    = rcsv_pkg::POS_CRC_LO;
        end
        rcsv_pkg::POS_CRC_LO: begin
          stored_next = stored_use;
          pos_next    = rcsv_pkg::POS_PAYLOAD;
        end
        default: begin
          pos_next = rcsv_pkg::POS_PAYLOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= rcsv_pkg::CRC_START;
      pos     <= rcsv_pkg::POS_VERSION;
      version <= 8'h00;
      stored  <= 16'h0000;
    end else if (fire) begin
      crc_reg <= crc_reg_next;
      pos     <= pos_next;
      version <= version_next;
      stored  <= stored_next;
    end
  end

endmodule

@@ design/rcsv_out_stage.sv @@
// Result register for the record CRC block.
// Depends on rcsv_pkg.
module rcsv_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  rcsv_pkg::res_t load_res,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output rcsv_pkg::res_t out_res
);

  logic           valid;
  rcsv_pkg::res_t res;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

@@ design/record_crc_seal_verify.sv @@
// Record CRC seal/verify engine. One byte request is taken per cycle while the
// stream is not stalled; each byte is held in the input register, then its
// CRC-16 (reflected 0xA001, start 0xFFFF) update and, on the last byte, the
// result are computed in one pass, and the result is loaded into the result
// register, which drives out_valid. Sustained rate is one byte per cycle,
// set by the unrolled byte-wide CRC fold; the stream stalls only while a
// finished result waits in the result register and the next last byte needs it.
// Depends on rcsv_pkg, rcsv_in_stage, rcsv_engine, rcsv_out_stage and the macros header.
`include "record_crc_seal_verify_macros.svh"

module record_crc_seal_verify (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] crc_value,
  output logic [1:0]  result_status
);

  rcsv_pkg::item_t in_item;
  rcsv_pkg::item_t stage_item;
  rcsv_pkg::res_t  eng_res;
  rcsv_pkg::res_t  out_res;
  logic            stage_valid;
  logic            out_free;
  logic            advance;
  logic            load;

  assign in_item.operation = operation;
  assign in_item.data_byte = data_byte;
  assign in_item.last      = last;

  // a last byte needs the result register; others pass freely
  assign advance = stage_valid && (!stage_item.last || out_free);
  assign load    = advance && stage_item.last;

  rcsv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .stage_valid(stage_valid),
    .stage_item (stage_item)
  );

  rcsv_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (stage_item),
    .result(eng_res)
  );

  rcsv_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .load_res (eng_res),
    .free     (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign crc_value     = out_res.crc_value;
  assign result_status = out_res.result_status;

  `RCSV_ASSERT_NXT(a_last_gives_result, clk, rst, load, out_valid, "last byte produced no result")
  `RCSV_ASSERT_IMP(a_stall_blocks_input, clk, rst, stage_valid && stage_item.last && !out_free, !in_ready, "input taken while last byte is stalled")
  `RCSV_ASSERT_NXT(a_mid_byte_keeps_result, clk, rst, advance && !stage_item.last && out_valid && !out_ready, out_valid && $stable(crc_value) && $stable(result_status), "non-last byte disturbed a waiting result")
  `RCSV_ASSERT_IMP(a_sealed_only_from_seal, clk, rst, load && stage_item.operation == rcsv_pkg::OP_VERIFY, eng_res.result_status != rcsv_pkg::STATUS_SEALED, "verify record reported as sealed")

endmodule
